FILE: hw/rtl/isort_pkg.sv
package isort_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int DATA_W       = 64;
    // element count runs 0..MAX_ELEMENTS inclusive
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    // front queue: two entries
    localparam int FQ_DEPTH     = 2;
    localparam int FQ_PTR_W     = 1;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         count_t;

    typedef struct packed {
        data_t value;
        logic  final_item;
    } item_t;

    typedef struct packed {
        data_t value;
        logic  last;
        logic  ovf;
    } result_t;

endpackage

FILE: hw/rtl/isort_fifo.sv
module isort_fifo
    import isort_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t               mem_reg [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] wr_ptr_reg;
    logic [FQ_PTR_W-1:0] rd_ptr_reg;
    logic [FQ_PTR_W:0]   fill_reg;
    logic [FQ_PTR_W:0]   fill_next;
    logic                push;
    logic                pop;

    assign in_ready  = (fill_reg != (FQ_PTR_W+1)'(FQ_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

FILE: hw/rtl/isort_array.sv
module isort_array
    import isort_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam logic ST_INSERT = 1'b0;
    localparam logic ST_DRAIN  = 1'b1;

    data_t  store_reg [MAX_ELEMENTS];
    count_t count_reg;
    count_t remain_reg;
    logic   ovf_reg;
    logic   state_reg;

    logic [MAX_ELEMENTS-1:0] gt;
    logic                    full;
    logic                    insert;
    logic                    store_wr;
    logic                    drain_step;

    assign in_ready   = (state_reg == ST_INSERT);
    assign res_valid  = (state_reg == ST_DRAIN);
    assign insert     = in_valid && in_ready;
    assign drain_step = res_valid && res_ready;
    assign full       = (count_reg == CNT_W'(MAX_ELEMENTS));
    assign store_wr   = insert && !full;

    assign res.value = store_reg[0];
    assign res.last  = (remain_reg == count_t'(1));
    assign res.ovf   = ovf_reg;

    // Each cell compares its entry against the incoming value; empty cells act as +inf.
    always_comb begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            gt[i] = (CNT_W'(i) >= count_reg) || (store_reg[i] > in_item.value);
        end
    end

    genvar c;
    generate
        for (c = 0; c < MAX_ELEMENTS; c++) begin : g_cell
            data_t shift_in;
            data_t drain_in;

            if (c == 0) begin : g_first
                assign shift_in = in_item.value;
            end else begin : g_rest
                assign shift_in = gt[c-1] ? store_reg[c-1] : in_item.value;
            end

            if (c == MAX_ELEMENTS - 1) begin : g_top
                assign drain_in = store_reg[c];
            end else begin : g_mid
                assign drain_in = store_reg[c+1];
            end

            always_ff @(posedge aclk) begin
                if (store_wr && gt[c]) begin
                    store_reg[c] <= shift_in;
                end else if (drain_step) begin
                    store_reg[c] <= drain_in;
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_INSERT;
            count_reg  <= '0;
            remain_reg <= '0;
            ovf_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_INSERT: begin
                    if (insert) begin
                        if (full) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (in_item.final_item) begin
                            state_reg  <= ST_DRAIN;
                            remain_reg <= full ? count_reg : count_reg + 1'b1;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (drain_step) begin
                        remain_reg <= remain_reg - 1'b1;
                        if (remain_reg == count_t'(1)) begin
                            state_reg <= ST_INSERT;
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_INSERT;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/insertion_sorter.sv
// A final value's transfer goes through the queue, the cell row's state register and the
// output register before the first sorted result appears on m_. Throughput: one value per
// cycle while a set is being filled; the compare-and-shift cell row inserts one value a
// cycle. Results are unloaded from cell 0, and insertion of the next set waits for the
// unload (the queue still takes up to two values meanwhile).
// Reset: aresetn synchronous, active low; clears count, overflow flag, queue and m_valid.
module insertion_sorter
    import isort_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [63:0] s_value,
    input  logic               s_final_item,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_sorted_value,
    output logic               m_last_out,
    output logic               m_overflowed
);

    // Front: a two-entry queue takes transfers and holds them for the cell row.
    item_t   s_item;
    item_t   q_item;
    logic    q_valid;
    logic    q_ready;

    // Back: the sorted cell row, unloaded from cell 0 by shifting down.
    result_t res;
    logic    res_valid;
    logic    res_ready;

    // Output register parts the cell row from the m_ side.
    logic               m_valid_reg;
    logic signed [63:0] m_sorted_value_reg;
    logic               m_last_out_reg;
    logic               m_overflowed_reg;

    assign s_item.value      = s_value;
    assign s_item.final_item = s_final_item;

    isort_fifo u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    isort_array u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Take a new result whenever the register is empty or being emptied.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_sorted_value_reg <= res.value;
            m_last_out_reg     <= res.last;
            m_overflowed_reg   <= res.ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_sorted_value_reg;
    assign m_last_out     = m_last_out_reg;
    assign m_overflowed   = m_overflowed_reg;

endmodule
